/* rtl/cds_pkg.sv */
// Shared types, constants and month-length lookup for the calendar date stepper.
package cds_pkg;

  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [WDAY_W-1:0] WDAY_FIRST = 3'd1;
  localparam logic [WDAY_W-1:0] WDAY_LAST  = 3'd7;
  localparam logic [WDAY_W-1:0] WDAY_NONE  = 3'd0;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_DEC_END = 5'd31;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 16'h0000;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 16'hFFFF;

  // Exact divisibility by 25: y * inv(25) mod 2^16 lands in [0, 65535/25]
  // exactly when y is a multiple of 25.
  localparam logic [YEAR_W-1:0] INV25_MOD   = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
  } cds_date_t;

  typedef struct packed {
    cds_date_t date;
    logic      year_wrapped;
    logic      input_bad;
  } cds_result_t;

  // Days in a month; months outside 1..12 give 0.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

/* rtl/cds_step.sv */
// Combinational next/previous day computation with range check.
module cds_step (
  input  logic              op,
  input  cds_pkg::cds_date_t  date_in,
  output cds_pkg::cds_result_t res
);
  import cds_pkg::*;

  logic [YEAR_W-1:0] mod_prod;
  logic              div25, div100, div400, div4, leap;
  logic [DAY_W-1:0]  cur_len, prev_len;
  logic              month_ok;

  assign mod_prod = YEAR_W'(date_in.year * INV25_MOD);
  assign div25    = (mod_prod <= DIV25_LIMIT);
  assign div4     = (date_in.year[1:0] == 2'b00);
  assign div100   = div25 && div4;
  assign div400   = div25 && (date_in.year[3:0] == 4'b0000);
  assign leap     = div400 || (div4 && !div100);

  assign cur_len  = month_len(date_in.month, leap);
  assign prev_len = month_len(date_in.month - MONTH_W'(1), leap);
  assign month_ok = (date_in.month inside {[MONTH_JAN:MONTH_DEC]});

  always_comb begin
    res.date         = date_in;
    res.year_wrapped = 1'b0;
    res.input_bad    = 1'b0;
    if (!month_ok || date_in.weekday == WDAY_NONE ||
        date_in.day == '0 || date_in.day > cur_len) begin
      res.input_bad = 1'b1;
    end else if (!op) begin
      res.date.weekday = (date_in.weekday == WDAY_LAST) ? WDAY_FIRST
                                                       : date_in.weekday + WDAY_W'(1);
      if (date_in.day == cur_len) begin
        res.date.day = DAY_FIRST;
        if (date_in.month == MONTH_DEC) begin
          res.date.month   = MONTH_JAN;
          res.date.year    = date_in.year + YEAR_W'(1);
          res.year_wrapped = (date_in.year == YEAR_MAX);
        end else begin
          res.date.month = date_in.month + MONTH_W'(1);
        end
      end else begin
        res.date.day = date_in.day + DAY_W'(1);
      end
    end else begin
      res.date.weekday = (date_in.weekday == WDAY_FIRST) ? WDAY_LAST
                                                        : date_in.weekday - WDAY_W'(1);
      if (date_in.day == DAY_FIRST) begin
        if (date_in.month == MONTH_JAN) begin
          res.date.month   = MONTH_DEC;
          res.date.day     = DAY_DEC_END;
          res.date.year    = date_in.year - YEAR_W'(1);
          res.year_wrapped = (date_in.year == YEAR_MIN);
        end else begin
          res.date.month = date_in.month - MONTH_W'(1);
          res.date.day   = prev_len;
        end
      end else begin
        res.date.day = date_in.day - DAY_W'(1);
      end
    end
  end

endmodule

/* rtl/calendar_date_step.sv */
// Top level of the calendar date stepper: input register, date logic, result register.
// Usage:
//   Input channel (in_*): one item per accepted handshake, carrying a date
//   (year, month, day of month, weekday 1..7) and an op bit: 0 steps to the
//   next day, 1 to the previous day. Accepted when in_valid && !in_stall.
//   Result channel (out_*): one item per input item, in order, with the new
//   date, out_year_wrapped when the year crossed 65535/0, and out_input_bad
//   when the input date was out of range (date then passed unchanged).
//   Accepted when out_valid && !out_stall.
// Timing:
//   An item lands in the input register, and the date
//   logic (leap test by one constant multiply, month table, +/-1 steps)
//   sits between it and the result register.
//   Throughput is one item per cycle while out_stall is low.
// Reset (rst_n low, synchronous) empties both stages; payload is not cleared.
// Stall: while out_stall is high a held result stays put, the input
//   register keeps its item, and in_stall rises once that register is full;
//   with two stages up to two items are held during a stall.
module calendar_date_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [cds_pkg::YEAR_W-1:0]    in_year,
  input  logic [cds_pkg::MONTH_W-1:0]   in_month,
  input  logic [cds_pkg::DAY_W-1:0]     in_day_of_month,
  input  logic [cds_pkg::WDAY_W-1:0]    in_weekday,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cds_pkg::YEAR_W-1:0]    out_new_year,
  output logic [cds_pkg::MONTH_W-1:0]   out_new_month,
  output logic [cds_pkg::DAY_W-1:0]     out_new_day,
  output logic [cds_pkg::WDAY_W-1:0]    out_new_weekday,
  output logic                          out_year_wrapped,
  output logic                          out_input_bad
);
  import cds_pkg::*;

  // input stage
  logic        in_valid_r, in_valid_nxt;
  logic        in_op_r;
  cds_date_t   in_date_r;

  // result stage
  logic        out_valid_r, out_valid_nxt;
  cds_result_t out_res_r;

  cds_result_t step_res;
  logic        out_load;   // result register takes the input stage
  logic        in_load;    // input register takes a new item

  cds_step u_step (
    .op      (in_op_r),
    .date_in (in_date_r),
    .res     (step_res)
  );

  // result register frees up when empty or being drained this cycle
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = in_valid_r;
    end
    in_valid_nxt = in_valid_r;
    if (in_load) begin
      in_valid_nxt = 1'b1;
    end else if (out_load) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_op_r           <= in_op;
      in_date_r.year    <= in_year;
      in_date_r.month   <= in_month;
      in_date_r.day     <= in_day_of_month;
      in_date_r.weekday <= in_weekday;
    end
    if (out_load && in_valid_r) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_year     = out_res_r.date.year;
  assign out_new_month    = out_res_r.date.month;
  assign out_new_day      = out_res_r.date.day;
  assign out_new_weekday  = out_res_r.date.weekday;
  assign out_year_wrapped = out_res_r.year_wrapped;
  assign out_input_bad    = out_res_r.input_bad;

endmodule
